// ===== rtl/rectangle_subtract_unit_assert.svh =====
// Assertion macros for the rectangle subtract unit.
`ifndef RECTANGLE_SUBTRACT_UNIT_ASSERT_SVH
`define RECTANGLE_SUBTRACT_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off during rst.
`define RSUB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rectangle_subtract_unit: assertion failed");
// Next-cycle implication, sampled on clk, off during rst.
`define RSUB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rectangle_subtract_unit: assertion failed");
`else
`define RSUB_ASSERT_NOW(lbl, ante, cons)
`define RSUB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/rsub_pkg.sv =====
// Shared types and constants of the rectangle subtract unit.
`default_nettype none
package rsub_pkg;

  localparam int COORD_WIDTH = 16;

  typedef enum logic [1:0] {
    OUTCOME_SAME = 2'd0,
    OUTCOME_GONE = 2'd1,
    OUTCOME_TRIM = 2'd2
  } outcome_t;

endpackage
`default_nettype wire

// ===== rtl/rsub_req_if.sv =====
// Request channel: the two rectangles A and B.
`default_nettype none
interface rsub_req_if #(
  parameter int COORD_WIDTH = rsub_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_left;
  logic signed [COORD_WIDTH-1:0] a_top;
  logic signed [COORD_WIDTH-1:0] a_right;
  logic signed [COORD_WIDTH-1:0] a_bottom;
  logic signed [COORD_WIDTH-1:0] b_left;
  logic signed [COORD_WIDTH-1:0] b_top;
  logic signed [COORD_WIDTH-1:0] b_right;
  logic signed [COORD_WIDTH-1:0] b_bottom;

  modport source (
    output valid, a_left, a_top, a_right, a_bottom,
    output b_left, b_top, b_right, b_bottom,
    input  ready
  );
  modport sink (
    input  valid, a_left, a_top, a_right, a_bottom,
    input  b_left, b_top, b_right, b_bottom,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/rsub_rsp_if.sv =====
// Response channel: the difference rectangle and its outcome code.
`default_nettype none
interface rsub_rsp_if #(
  parameter int COORD_WIDTH = rsub_pkg::COORD_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic signed [COORD_WIDTH:0] out_left;
  logic signed [COORD_WIDTH:0] out_top;
  logic signed [COORD_WIDTH:0] out_right;
  logic signed [COORD_WIDTH:0] out_bottom;
  rsub_pkg::outcome_t          outcome;

  modport source (
    output valid, out_left, out_top, out_right, out_bottom, outcome,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_top, out_right, out_bottom, outcome,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/rsub_core.sv =====
// Combinational rectangle difference: normalize, classify overlap, trim.
`default_nettype none
module rsub_core #(
  parameter int COORD_WIDTH = rsub_pkg::COORD_WIDTH
) (
  input  wire logic signed [COORD_WIDTH-1:0] a_left,
  input  wire logic signed [COORD_WIDTH-1:0] a_top,
  input  wire logic signed [COORD_WIDTH-1:0] a_right,
  input  wire logic signed [COORD_WIDTH-1:0] a_bottom,
  input  wire logic signed [COORD_WIDTH-1:0] b_left,
  input  wire logic signed [COORD_WIDTH-1:0] b_top,
  input  wire logic signed [COORD_WIDTH-1:0] b_right,
  input  wire logic signed [COORD_WIDTH-1:0] b_bottom,
  output logic signed [COORD_WIDTH:0]        out_left,
  output logic signed [COORD_WIDTH:0]        out_top,
  output logic signed [COORD_WIDTH:0]        out_right,
  output logic signed [COORD_WIDTH:0]        out_bottom,
  output rsub_pkg::outcome_t                 outcome
);

  localparam int OW = COORD_WIDTH + 1;
  localparam logic signed [OW-1:0] ONE = OW'(1);

  logic signed [OW-1:0] al, at, ar, ab, bl, bt, br, bb;
  logic signed [OW-1:0] nal, nat, nar, nab, nbl, nbt, nbr, nbb;
  logic                 span_x, span_y, apart;

  // Sign-extend by one bit so the +1 of normalization cannot wrap.
  assign al = {a_left[COORD_WIDTH-1], a_left};
  assign at = {a_top[COORD_WIDTH-1], a_top};
  assign ar = {a_right[COORD_WIDTH-1], a_right};
  assign ab = {a_bottom[COORD_WIDTH-1], a_bottom};
  assign bl = {b_left[COORD_WIDTH-1], b_left};
  assign bt = {b_top[COORD_WIDTH-1], b_top};
  assign br = {b_right[COORD_WIDTH-1], b_right};
  assign bb = {b_bottom[COORD_WIDTH-1], b_bottom};

  // Reversed pair (lo, hi) becomes (hi+1, lo+1).
  assign nal = (al > ar) ? ar + ONE : al;
  assign nar = (al > ar) ? al + ONE : ar;
  assign nat = (at > ab) ? ab + ONE : at;
  assign nab = (at > ab) ? at + ONE : ab;
  assign nbl = (bl > br) ? br + ONE : bl;
  assign nbr = (bl > br) ? bl + ONE : br;
  assign nbt = (bt > bb) ? bb + ONE : bt;
  assign nbb = (bt > bb) ? bt + ONE : bb;

  assign apart  = (nal >= nbr) || (nat >= nbb) || (nar <= nbl) || (nab <= nbt);
  assign span_x = (nal >= nbl) && (nar <= nbr);
  assign span_y = (nat >= nbt) && (nab <= nbb);

  always_comb begin
    out_left   = al;
    out_top    = at;
    out_right  = ar;
    out_bottom = ab;
    outcome    = rsub_pkg::OUTCOME_SAME;
    if (apart) begin
      // keep original A
    end else if (span_x && span_y) begin
      out_left   = '0;
      out_top    = '0;
      out_right  = '0;
      out_bottom = '0;
      outcome    = rsub_pkg::OUTCOME_GONE;
    end else if (span_x) begin
      if (nbt <= nat) begin
        out_left   = nal;
        out_top    = nbb;
        out_right  = nar;
        out_bottom = nab;
        outcome    = rsub_pkg::OUTCOME_TRIM;
      end else if (nbb >= nab) begin
        out_left   = nal;
        out_top    = nat;
        out_right  = nar;
        out_bottom = nbt;
        outcome    = rsub_pkg::OUTCOME_TRIM;
      end
    end else if (span_y) begin
      if (nbl <= nal) begin
        out_left   = nbr;
        out_top    = nat;
        out_right  = nar;
        out_bottom = nab;
        outcome    = rsub_pkg::OUTCOME_TRIM;
      end else if (nbr >= nar) begin
        out_left   = nal;
        out_top    = nat;
        out_right  = nbl;
        out_bottom = nab;
        outcome    = rsub_pkg::OUTCOME_TRIM;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rectangle_subtract_unit.sv =====
// Rectangle subtract unit: A minus B with an input and a result register.
//
// Usage:
//   req carries rectangle A (a_*) and rectangle B (b_*), signed edges.
//   rsp carries the difference rectangle (out_*, one bit wider) and an
//   outcome code: unchanged, fully covered (all zero) or trimmed.
//   Both channels move a word when valid and ready are high at a clock edge.
// Path: a word taken on req passes the input register, then the result
//   register, to rsp; the classify/trim logic sits between.
// Throughput: one word per cycle while rsp is ready, set by the two-register
//   pipeline; the difference logic holds no state from one word to the next.
// Stall: while rsp is held off, the result register keeps its word and
//   req takes one more word into the input register if it is empty; then
//   req.ready drops until rsp drains.
// Reset: rst (synchronous, active high) empties both registers; rsp.valid
//   goes low and req.ready is high from the first cycle after reset.
`default_nettype none
`include "rectangle_subtract_unit_assert.svh"
module rectangle_subtract_unit #(
  parameter int COORD_WIDTH = rsub_pkg::COORD_WIDTH
) (
  input wire logic   clk,
  input wire logic   rst,
  rsub_req_if.sink   req,
  rsub_rsp_if.source rsp
);

  logic                          in_valid;
  logic signed [COORD_WIDTH-1:0] a_left, a_top, a_right, a_bottom;
  logic signed [COORD_WIDTH-1:0] b_left, b_top, b_right, b_bottom;

  logic signed [COORD_WIDTH:0]   res_left, res_top, res_right, res_bottom;
  rsub_pkg::outcome_t            res_outcome;

  logic                          out_ready;
  logic                          in_ready;

  assign out_ready = !rsp.valid || rsp.ready;
  assign in_ready  = !in_valid || out_ready;
  assign req.ready = in_ready;

  // Input register: hold its word while the result register is blocked.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= req.valid;
    end
    if (in_ready && req.valid) begin
      a_left   <= req.a_left;
      a_top    <= req.a_top;
      a_right  <= req.a_right;
      a_bottom <= req.a_bottom;
      b_left   <= req.b_left;
      b_top    <= req.b_top;
      b_right  <= req.b_right;
      b_bottom <= req.b_bottom;
    end
  end

  rsub_core #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_core (
    .a_left     (a_left),
    .a_top      (a_top),
    .a_right    (a_right),
    .a_bottom   (a_bottom),
    .b_left     (b_left),
    .b_top      (b_top),
    .b_right    (b_right),
    .b_bottom   (b_bottom),
    .out_left   (res_left),
    .out_top    (res_top),
    .out_right  (res_right),
    .out_bottom (res_bottom),
    .outcome    (res_outcome)
  );

  // Result register: advance when empty or when the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_ready) begin
      rsp.valid <= in_valid;
    end
    if (out_ready && in_valid) begin
      rsp.out_left   <= res_left;
      rsp.out_top    <= res_top;
      rsp.out_right  <= res_right;
      rsp.out_bottom <= res_bottom;
      rsp.outcome    <= res_outcome;
    end
  end

  `RSUB_ASSERT_NOW(a_gone_zero, rsp.valid && rsp.outcome == rsub_pkg::OUTCOME_GONE, rsp.out_left == '0 && rsp.out_top == '0 && rsp.out_right == '0 && rsp.out_bottom == '0)
  `RSUB_ASSERT_NEXT(a_advance, in_valid && out_ready, rsp.valid)
  `RSUB_ASSERT_NEXT(a_no_invent, !in_valid && !rsp.valid, !rsp.valid)
  `RSUB_ASSERT_NEXT(a_take_empty, req.valid && !in_valid, in_valid)

endmodule
`default_nettype wire

// ===== tb/rectangle_subtract_unit_test.sv =====
// Self-checking testbench for rectangle_subtract_unit: directed table, then random pairs.
`timescale 1ns / 1ps
module rectangle_subtract_unit_test;

  localparam int CW = rsub_pkg::COORD_WIDTH;
  localparam int MINC = -(2 ** (CW - 1));
  localparam int MAXC = 2 ** (CW - 1) - 1;
  localparam int PRED = 0;
  localparam int TYPED = 1;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 643;
  localparam int N_DIRECTED = 21;

  typedef struct {
    logic signed [CW-1:0] a_left, a_top, a_right, a_bottom;
    logic signed [CW-1:0] b_left, b_top, b_right, b_bottom;
  } rect_pair_t;

  typedef struct {
    logic signed [CW:0] left, top, right, bottom;
    rsub_pkg::outcome_t outcome;
  } diff_rect_t;

  // columns: A l t r b, B l t r b, check kind, result l t r b, outcome
  localparam int DIRECTED [N_DIRECTED][14] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, TYPED, 0, 0, 0, 0, rsub_pkg::OUTCOME_SAME},
    '{MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC,
      TYPED, 0, 0, 0, 0, rsub_pkg::OUTCOME_GONE},
    '{MAXC, MAXC, MINC, MINC, MINC, MINC, MAXC, MAXC,
      TYPED, MAXC, MAXC, MINC, MINC, rsub_pkg::OUTCOME_SAME},
    '{MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, PRED, 0, 0, 0, 0, 0},
    '{MAXC, MAXC, MINC, MINC, MAXC, MAXC, MINC, MINC,
      TYPED, 0, 0, 0, 0, rsub_pkg::OUTCOME_GONE},
    '{MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC,
      TYPED, MINC, MINC, MINC, MINC, rsub_pkg::OUTCOME_SAME},
    '{MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC,
      TYPED, MAXC, MAXC, MAXC, MAXC, rsub_pkg::OUTCOME_SAME},
    '{0, 0, 10, 10, -5, -5, 20, 4, PRED, 0, 0, 0, 0, 0},
    '{0, 0, 10, 10, -5, 6, 20, 15, PRED, 0, 0, 0, 0, 0},
    '{0, 0, 10, 10, -5, 3, 20, 7, PRED, 0, 0, 0, 0, 0},
    '{0, 0, 10, 10, -5, -5, 4, 20, PRED, 0, 0, 0, 0, 0},
    '{0, 0, 10, 10, 6, -5, 15, 20, PRED, 0, 0, 0, 0, 0},
    '{0, 0, 10, 10, 3, -5, 7, 20, PRED, 0, 0, 0, 0, 0},
    '{0, 0, 10, 10, 2, 2, 8, 8, PRED, 0, 0, 0, 0, 0},
    '{0, 0, 10, 10, 10, 0, 20, 10, TYPED, 0, 0, 10, 10, rsub_pkg::OUTCOME_SAME},
    '{0, 0, 10, 10, 0, 10, 10, 20, TYPED, 0, 0, 10, 10, rsub_pkg::OUTCOME_SAME},
    '{10, 10, 0, 0, -5, -5, 20, 4, PRED, 0, 0, 0, 0, 0},
    '{0, 0, 10, 10, 20, 4, -5, -5, PRED, 0, 0, 0, 0, 0},
    '{MAXC, -10, MINC, 10, MAXC, -20, MINC, 0, PRED, 0, 0, 0, 0, 0},
    '{5, 0, 5, 10, 0, 0, 10, 10, PRED, 0, 0, 0, 0, 0},
    '{1, 2, 3, 4, 1, 2, 3, 4, TYPED, 0, 0, 0, 0, rsub_pkg::OUTCOME_GONE}
  };

  logic clk;
  logic rst;

  rsub_req_if req ();
  rsub_rsp_if rsp ();

  rectangle_subtract_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  diff_rect_t pending_diffs[$];
  int         mismatches = 0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  int         quiet_cycles = 0;
  bit         hold_rsp = 1'b0;
  diff_rect_t got_diff;
  diff_rect_t want_diff;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reversed pair (lo > hi) becomes (hi+1, lo+1)
  function automatic void order_span(input int lo, input int hi, output int nlo,
                                     output int nhi);
    if (lo > hi) begin
      nlo = hi + 1;
      nhi = lo + 1;
    end else begin
      nlo = lo;
      nhi = hi;
    end
  endfunction

  function automatic diff_rect_t predict_difference(rect_pair_t p);
    int         al, at, ar, ab, bl, bt, br, bb;
    bit         span_x, span_y, overlap;
    diff_rect_t d;
    order_span(int'(p.a_left), int'(p.a_right), al, ar);
    order_span(int'(p.a_top), int'(p.a_bottom), at, ab);
    order_span(int'(p.b_left), int'(p.b_right), bl, br);
    order_span(int'(p.b_top), int'(p.b_bottom), bt, bb);
    d.left = (CW+1)'(p.a_left);
    d.top = (CW+1)'(p.a_top);
    d.right = (CW+1)'(p.a_right);
    d.bottom = (CW+1)'(p.a_bottom);
    d.outcome = rsub_pkg::OUTCOME_SAME;
    span_x = (al >= bl) && (ar <= br);
    span_y = (at >= bt) && (ab <= bb);
    overlap = (al < br) && (at < bb) && (ar > bl) && (ab > bt);
    if (overlap) begin
      if (span_x && span_y) begin
        d.left = '0;
        d.top = '0;
        d.right = '0;
        d.bottom = '0;
        d.outcome = rsub_pkg::OUTCOME_GONE;
      end else if (span_x) begin
        if (bt <= at || bb >= ab) begin
          d.left = (CW+1)'(al);
          d.right = (CW+1)'(ar);
          d.top = (CW+1)'((bt <= at) ? bb : at);
          d.bottom = (CW+1)'((bt <= at) ? ab : bt);
          d.outcome = rsub_pkg::OUTCOME_TRIM;
        end
      end else if (span_y) begin
        if (bl <= al || br >= ar) begin
          d.top = (CW+1)'(at);
          d.bottom = (CW+1)'(ab);
          d.left = (CW+1)'((bl <= al) ? br : al);
          d.right = (CW+1)'((bl <= al) ? ar : bl);
          d.outcome = rsub_pkg::OUTCOME_TRIM;
        end
      end
    end
    return d;
  endfunction

  function automatic int random_coord();
    case ($urandom_range(0, 9))
      0: return MINC;
      1: return MAXC;
      default: return int'($urandom_range(0, MAXC - MINC)) + MINC;
    endcase
  endfunction

  function automatic int random_extent();
    if ($urandom_range(0, 99) < 90) return int'($urandom_range(0, 40));
    return int'($urandom_range(0, MAXC - MINC));
  endfunction

  // B edge placed around the matching A edge, biased toward ties and spans
  function automatic int near_edge(int own, int other, int outward);
    case ($urandom_range(0, 7))
      0, 1, 2: return own + int'($urandom_range(0, 4)) - 2;
      3: return other + int'($urandom_range(0, 4)) - 2;
      4, 5, 6: return own + outward * int'($urandom_range(1, 30));
      default: return random_coord();
    endcase
  endfunction

  function automatic rect_pair_t random_pair();
    rect_pair_t p;
    int         al, at, ar, ab;
    if ($urandom_range(0, 99) < 20) begin
      p.a_left = CW'($urandom());
      p.a_top = CW'($urandom());
      p.a_right = CW'($urandom());
      p.a_bottom = CW'($urandom());
      p.b_left = CW'($urandom());
      p.b_top = CW'($urandom());
      p.b_right = CW'($urandom());
      p.b_bottom = CW'($urandom());
      return p;
    end
    al = random_coord();
    at = random_coord();
    ar = al + random_extent();
    ab = at + random_extent();
    p.a_left = CW'(al);
    p.a_top = CW'(at);
    p.a_right = CW'(ar);
    p.a_bottom = CW'(ab);
    p.b_left = CW'(near_edge(al, ar, -1));
    p.b_right = CW'(near_edge(ar, al, 1));
    p.b_top = CW'(near_edge(at, ab, -1));
    p.b_bottom = CW'(near_edge(ab, at, 1));
    // reverse some pairs so normalization is exercised
    if ($urandom_range(0, 3) == 0) {p.a_left, p.a_right} = {p.a_right, p.a_left};
    if ($urandom_range(0, 3) == 0) {p.a_top, p.a_bottom} = {p.a_bottom, p.a_top};
    if ($urandom_range(0, 3) == 0) {p.b_left, p.b_right} = {p.b_right, p.b_left};
    if ($urandom_range(0, 3) == 0) {p.b_top, p.b_bottom} = {p.b_bottom, p.b_top};
    return p;
  endfunction

  task automatic send_word(input rect_pair_t p, input diff_rect_t want);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.a_left = p.a_left;
    req.a_top = p.a_top;
    req.a_right = p.a_right;
    req.a_bottom = p.a_bottom;
    req.b_left = p.b_left;
    req.b_top = p.b_top;
    req.b_right = p.b_right;
    req.b_bottom = p.b_bottom;
    req.valid = 1'b1;
    do @(posedge clk); while (!req.ready);
    pending_diffs.push_back(want);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    req.valid = 1'b0;
    while (pending_diffs.size() != 0) @(negedge clk);
  endtask

  task automatic send_random(input int count);
    rect_pair_t p;
    for (int n = 0; n < count; n++) begin
      p = random_pair();
      send_word(p, predict_difference(p));
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // response side: random ready, plus one long hold-off on request
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end
      rsp.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      got_diff.left = rsp.out_left;
      got_diff.top = rsp.out_top;
      got_diff.right = rsp.out_right;
      got_diff.bottom = rsp.out_bottom;
      got_diff.outcome = rsp.outcome;
      if (pending_diffs.size() == 0) begin
        $error("unexpected result word: left %0d top %0d right %0d bottom %0d",
               got_diff.left, got_diff.top, got_diff.right, got_diff.bottom);
        mismatches++;
      end else begin
        want_diff = pending_diffs.pop_front();
        check_field("out_left", 32'(want_diff.left), 32'(got_diff.left));
        check_field("out_top", 32'(want_diff.top), 32'(got_diff.top));
        check_field("out_right", 32'(want_diff.right), 32'(got_diff.right));
        check_field("out_bottom", 32'(want_diff.bottom), 32'(got_diff.bottom));
        check_field("outcome", 32'(want_diff.outcome), 32'(got_diff.outcome));
      end
    end
  end

  // end the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rect_pair_t p;
    diff_rect_t want;
    rst = 1'b1;
    req.valid = 1'b0;
    req.a_left = '0;
    req.a_top = '0;
    req.a_right = '0;
    req.a_bottom = '0;
    req.b_left = '0;
    req.b_top = '0;
    req.b_right = '0;
    req.b_bottom = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    snd_idle_pct = 28;
    rcv_idle_pct = 73;
    for (int i = 0; i < N_DIRECTED; i++) begin
      p.a_left = CW'(DIRECTED[i][0]);
      p.a_top = CW'(DIRECTED[i][1]);
      p.a_right = CW'(DIRECTED[i][2]);
      p.a_bottom = CW'(DIRECTED[i][3]);
      p.b_left = CW'(DIRECTED[i][4]);
      p.b_top = CW'(DIRECTED[i][5]);
      p.b_right = CW'(DIRECTED[i][6]);
      p.b_bottom = CW'(DIRECTED[i][7]);
      if (DIRECTED[i][8] == TYPED) begin
        want.left = (CW+1)'(DIRECTED[i][9]);
        want.top = (CW+1)'(DIRECTED[i][10]);
        want.right = (CW+1)'(DIRECTED[i][11]);
        want.bottom = (CW+1)'(DIRECTED[i][12]);
        want.outcome = rsub_pkg::outcome_t'(DIRECTED[i][13]);
      end else begin
        want = predict_difference(p);
      end
      send_word(p, want);
    end
    send_random(PHASE_ITEMS);
    wait_for_results();

    snd_idle_pct = 73;
    rcv_idle_pct = 28;
    send_random(PHASE_ITEMS);
    wait_for_results();

    // no idling; hold the result side off so the pipeline fills and stalls
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_random(100);
    hold_rsp = 1'b1;
    send_random(PHASE_ITEMS - 100);
    wait_for_results();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending_diffs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
